### rtl/maze_wall_union_find_unit_defines.svh
// Assertion helpers for maze_wall_union_find_unit.sv, the RTL file that carries concurrent checks.
// Each macro samples on clock and is disabled while reset is high.
`ifndef MAZE_WALL_UNION_FIND_UNIT_DEFINES_SVH
`define MAZE_WALL_UNION_FIND_UNIT_DEFINES_SVH

`define MWUF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define MWUF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mwuf_pkg.sv
`default_nettype none

package mwuf_pkg;

   localparam int CELL_IN_W = 10;
   localparam int GRID_W    = 11;
   localparam int SLOT_W    = 11;
   localparam int CNT_W     = 12;
   localparam int RANK_W    = 4;

   localparam logic [RANK_W-1:0] RANK_MAX   = 4'd15;
   localparam logic [GRID_W-1:0] GRID_RESET = 11'd1024;
   localparam logic              ACT_WALL    = 1'b0;
   localparam logic              ACT_RESTART = 1'b1;

   typedef enum logic [1:0] {
      ST_OPENED  = 2'd0,
      ST_KEPT    = 2'd1,
      ST_RESTART = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
   } result_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FIND_A,
      S_FIND_B,
      S_RANK,
      S_REPLY
   } state_type;

endpackage

`default_nettype wire

### rtl/maze_wall_union_find_unit.sv
// An out-of-range beat goes from idle straight to the reply state; a wall walks cell A to its
// root, then cell B, one parent hop per table read, then writes the join if the roots differ,
// plus a rank step if equal ranks below the maximum are joined. One beat is taken at a time;
// each hop is one read through the single read port of the set table. A restart clears all
// MAX_CELLS table entries, one per cycle, then replies. Reset (synchronous, active high) runs
// the same clearing pass with req_stall high; configuration writes are taken throughout.
`default_nettype none
`include "maze_wall_union_find_unit_defines.svh"

module maze_wall_union_find_unit #(
   parameter int MAX_CELLS = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_action,
   input  wire logic [mwuf_pkg::CELL_IN_W-1:0] req_cell_a,
   input  wire logic [mwuf_pkg::CELL_IN_W-1:0] req_cell_b,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [mwuf_pkg::SLOT_W-1:0]         rsp_slot,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mwuf_pkg::GRID_W-1:0]    csr_grid_cells
);

   logic [mwuf_pkg::GRID_W-1:0] grid_cells_ff;
   logic                        rsp_valid_ff;
   mwuf_pkg::result_type        rsp_res_ff;
   logic                        seq_idle;
   logic                        seq_done;
   mwuf_pkg::result_type        seq_result;
   logic                        out_free;
   logic                        req_take;

   assign csr_ready = 1'b1;
   assign req_stall = !seq_idle;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cells_ff <= mwuf_pkg::GRID_RESET;
      end else if (csr_valid && csr_ready) begin
         grid_cells_ff <= csr_grid_cells;
      end
   end

   mwuf_seq #(
      .MAX_CELLS(MAX_CELLS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_take  (req_take),
      .req_action(req_action),
      .req_cell_a(req_cell_a),
      .req_cell_b(req_cell_b),
      .grid_cells(grid_cells_ff),
      .out_free  (out_free),
      .idle      (seq_idle),
      .done      (seq_done),
      .result    (seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (seq_done) begin
         rsp_res_ff <= seq_result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_res_ff.status;
   assign rsp_slot   = rsp_res_ff.slot;

   `MWUF_ASSERT_NOW(a_done_when_free, seq_done, out_free, "result produced into a full output beat")
   `MWUF_ASSERT_NOW(a_idle_no_done, !req_stall, !seq_done, "result pending while input is open")
   `MWUF_ASSERT_NEXT(a_restart_busy, req_take && req_action == mwuf_pkg::ACT_RESTART, req_stall, "restart did not start clearing")
   `MWUF_ASSERT_NOW(a_zero_slot, rsp_valid_ff && (rsp_res_ff.status == mwuf_pkg::ST_RESTART || rsp_res_ff.status == mwuf_pkg::ST_RANGE), rsp_res_ff.slot == '0, "nonzero slot on restart or range beat")

endmodule

`default_nettype wire

### rtl/mwuf_ram.sv
`default_nettype none

module mwuf_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/mwuf_seq.sv
`default_nettype none

module mwuf_seq #(
   parameter int MAX_CELLS = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_take,
   input  wire logic                           req_action,
   input  wire logic [mwuf_pkg::CELL_IN_W-1:0] req_cell_a,
   input  wire logic [mwuf_pkg::CELL_IN_W-1:0] req_cell_b,
   input  wire logic [mwuf_pkg::GRID_W-1:0]    grid_cells,
   input  wire logic                           out_free,
   output logic                                idle,
   output logic                                done,
   output mwuf_pkg::result_type                result
);

   localparam int CELL_W  = $clog2(MAX_CELLS);
   localparam int ENTRY_W = mwuf_pkg::RANK_W + CELL_W;
   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(MAX_CELLS - 1);

   mwuf_pkg::state_type  state_ff, state_in;
   mwuf_pkg::result_type res_ff, res_in;
   logic [CELL_W-1:0]    cur_ff, cur_in;
   logic [CELL_W-1:0]    cell_b_ff, cell_b_in;
   logic [CELL_W-1:0]    root_a_ff, root_a_in;
   logic [mwuf_pkg::RANK_W-1:0] rank_a_ff, rank_a_in;
   logic [CELL_W-1:0]    clr_idx_ff, clr_idx_in;
   logic                 clr_reply_ff, clr_reply_in;
   logic [mwuf_pkg::CNT_W-1:0] opened_ff, opened_in;
   logic [mwuf_pkg::CNT_W-1:0] kept_ff, kept_in;

   logic                 ram_we;
   logic [CELL_W-1:0]    ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic [CELL_W-1:0]    ram_raddr;
   logic [ENTRY_W-1:0]   ram_rdata;
   logic [CELL_W-1:0]    rd_parent;
   logic [mwuf_pkg::RANK_W-1:0] rd_rank;
   logic                 a_ok;
   logic                 b_ok;

   mwuf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_CELLS)
   ) u_sets (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd_parent = ram_rdata[CELL_W-1:0];
   assign rd_rank   = ram_rdata[ENTRY_W-1 -: mwuf_pkg::RANK_W];

   assign a_ok = (32'(req_cell_a) < 32'(grid_cells)) && (32'(req_cell_a) < 32'(MAX_CELLS));
   assign b_ok = (32'(req_cell_b) < 32'(grid_cells)) && (32'(req_cell_b) < 32'(MAX_CELLS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwuf_pkg::S_CLEAR;
         clr_idx_ff   <= '0;
         clr_reply_ff <= 1'b0;
         opened_ff    <= '0;
         kept_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         clr_reply_ff <= clr_reply_in;
         opened_ff    <= opened_in;
         kept_ff      <= kept_in;
      end
      res_ff    <= res_in;
      cur_ff    <= cur_in;
      cell_b_ff <= cell_b_in;
      root_a_ff <= root_a_in;
      rank_a_ff <= rank_a_in;
   end

   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      cur_in       = cur_ff;
      cell_b_in    = cell_b_ff;
      root_a_in    = root_a_ff;
      rank_a_in    = rank_a_ff;
      clr_idx_in   = clr_idx_ff;
      clr_reply_in = clr_reply_ff;
      opened_in    = opened_ff;
      kept_in      = kept_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_idx_ff;
      ram_wdata    = {{mwuf_pkg::RANK_W{1'b0}}, clr_idx_ff};
      ram_raddr    = cur_ff;
      done         = 1'b0;

      case (state_ff)
         mwuf_pkg::S_CLEAR: begin
            ram_we     = 1'b1;
            clr_idx_in = clr_idx_ff + CELL_W'(1);
            if (clr_idx_ff == LAST_CELL) begin
               clr_idx_in   = '0;
               clr_reply_in = 1'b0;
               state_in     = clr_reply_ff ? mwuf_pkg::S_REPLY : mwuf_pkg::S_IDLE;
            end
         end
         mwuf_pkg::S_IDLE: begin
            if (req_take) begin
               if (req_action == mwuf_pkg::ACT_RESTART) begin
                  res_in       = '{status: mwuf_pkg::ST_RESTART, slot: '0};
                  opened_in    = '0;
                  kept_in      = '0;
                  clr_reply_in = 1'b1;
                  state_in     = mwuf_pkg::S_CLEAR;
               end else if (!(a_ok && b_ok)) begin
                  res_in   = '{status: mwuf_pkg::ST_RANGE, slot: '0};
                  state_in = mwuf_pkg::S_REPLY;
               end else begin
                  cur_in    = CELL_W'(req_cell_a);
                  cell_b_in = CELL_W'(req_cell_b);
                  ram_raddr = CELL_W'(req_cell_a);
                  state_in  = mwuf_pkg::S_FIND_A;
               end
            end
         end
         mwuf_pkg::S_FIND_A: begin
            if (rd_parent == cur_ff) begin
               root_a_in = cur_ff;
               rank_a_in = rd_rank;
               cur_in    = cell_b_ff;
               ram_raddr = cell_b_ff;
               state_in  = mwuf_pkg::S_FIND_B;
            end else begin
               cur_in    = rd_parent;
               ram_raddr = rd_parent;
            end
         end
         mwuf_pkg::S_FIND_B: begin
            if (rd_parent == cur_ff) begin
               if (cur_ff == root_a_ff) begin
                  res_in   = '{status: mwuf_pkg::ST_KEPT,
                               slot: kept_ff[mwuf_pkg::SLOT_W-1:0]};
                  kept_in  = kept_ff + mwuf_pkg::CNT_W'(1);
                  state_in = mwuf_pkg::S_REPLY;
               end else begin
                  res_in    = '{status: mwuf_pkg::ST_OPENED,
                                slot: opened_ff[mwuf_pkg::SLOT_W-1:0]};
                  opened_in = opened_ff + mwuf_pkg::CNT_W'(1);
                  ram_we    = 1'b1;
                  if (rank_a_ff < rd_rank) begin
                     ram_waddr = root_a_ff;
                     ram_wdata = {rank_a_ff, cur_ff};
                     state_in  = mwuf_pkg::S_REPLY;
                  end else begin
                     ram_waddr = cur_ff;
                     ram_wdata = {rd_rank, root_a_ff};
                     if (rank_a_ff == rd_rank && rank_a_ff != mwuf_pkg::RANK_MAX) begin
                        state_in = mwuf_pkg::S_RANK;
                     end else begin
                        state_in = mwuf_pkg::S_REPLY;
                     end
                  end
               end
            end else begin
               cur_in    = rd_parent;
               ram_raddr = rd_parent;
            end
         end
         mwuf_pkg::S_RANK: begin
            ram_we    = 1'b1;
            ram_waddr = root_a_ff;
            ram_wdata = {rank_a_ff + mwuf_pkg::RANK_W'(1), root_a_ff};
            state_in  = mwuf_pkg::S_REPLY;
         end
         mwuf_pkg::S_REPLY: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = mwuf_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mwuf_pkg::S_IDLE;
         end
      endcase
   end

   assign idle   = (state_ff == mwuf_pkg::S_IDLE);
   assign result = res_ff;

endmodule

`default_nettype wire

### tb/mwuf_checker.sv
module mwuf_checker #(
   parameter int MAX_CELLS = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic                           req_action,
   input  wire logic [mwuf_pkg::CELL_IN_W-1:0] req_cell_a,
   input  wire logic [mwuf_pkg::CELL_IN_W-1:0] req_cell_b,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [1:0]                     rsp_status,
   input  wire logic [mwuf_pkg::SLOT_W-1:0]    rsp_slot,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [mwuf_pkg::GRID_W-1:0]    csr_grid_cells,
   output int                                  mismatches,
   output int                                  pending,
   output int                                  opened_seen,
   output int                                  kept_seen,
   output int                                  restart_seen,
   output int                                  range_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import mwuf_pkg::*;

   logic [CELL_IN_W-1:0] cell_parent [MAX_CELLS];
   logic [RANK_W-1:0]    cell_rank [MAX_CELLS];
   logic [CNT_W-1:0]     opened_total;
   logic [CNT_W-1:0]     kept_total;
   logic [GRID_W-1:0]    grid_cells;
   result_type           wall_verdicts [$];

   function automatic void reset_forest();
      for (int i = 0; i < MAX_CELLS; i++) begin
         cell_parent[i] = i[CELL_IN_W-1:0];
         cell_rank[i] = '0;
      end
      opened_total = '0;
      kept_total = '0;
   endfunction

   function automatic logic [CELL_IN_W-1:0] root_of(logic [CELL_IN_W-1:0] c);
      logic [CELL_IN_W-1:0] walk;
      walk = c;
      for (int n = 0; n < MAX_CELLS && cell_parent[walk] != walk; n++)
         walk = cell_parent[walk];
      return walk;
   endfunction

   function automatic result_type carve_wall(logic act, logic [CELL_IN_W-1:0] a,
                                             logic [CELL_IN_W-1:0] b);
      result_type           r;
      logic [GRID_W-1:0]    cells;
      logic [CELL_IN_W-1:0] ra;
      logic [CELL_IN_W-1:0] rb;
      cells = (grid_cells > MAX_CELLS) ? GRID_W'(MAX_CELLS) : grid_cells;
      r.slot = '0;
      if (act == ACT_RESTART) begin
         reset_forest();
         r.status = ST_RESTART;
      end else if ({1'b0, a} >= cells || {1'b0, b} >= cells) begin
         r.status = ST_RANGE;
      end else begin
         ra = root_of(a);
         rb = root_of(b);
         if (ra == rb) begin
            r.status = ST_KEPT;
            r.slot = kept_total[SLOT_W-1:0];
            kept_total = kept_total + 1'b1;
         end else begin
            if (cell_rank[ra] < cell_rank[rb]) begin
               cell_parent[ra] = rb;
            end else if (cell_rank[ra] > cell_rank[rb]) begin
               cell_parent[rb] = ra;
            end else begin
               cell_parent[rb] = ra;
               if (cell_rank[ra] != RANK_MAX)
                  cell_rank[ra] = cell_rank[ra] + 1'b1;
            end
            r.status = ST_OPENED;
            r.slot = opened_total[SLOT_W-1:0];
            opened_total = opened_total + 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         reset_forest();
         grid_cells = GRID_RESET;
         wall_verdicts.delete();
         mismatches = 0;
         opened_seen = 0;
         kept_seen = 0;
         restart_seen = 0;
         range_seen = 0;
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (wall_verdicts.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with nothing expected: status %0d slot %0d",
                        $time, rsp_status, rsp_slot);
            end else begin
               want = wall_verdicts.pop_front();
               if (rsp_status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_slot !== want.slot) begin
                  mismatches++;
                  $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_slot);
               end
               case (want.status)
                  ST_OPENED:  opened_seen++;
                  ST_KEPT:    kept_seen++;
                  ST_RESTART: restart_seen++;
                  default:    range_seen++;
               endcase
            end
         end
         if (req_valid && !req_stall)
            wall_verdicts.insert(wall_verdicts.size(),
                                 carve_wall(req_action, req_cell_a, req_cell_b));
         if (csr_valid && csr_ready)
            grid_cells = csr_grid_cells;
         pending <= wall_verdicts.size();
      end
   end

endmodule

### tb/maze_wall_union_find_unit_tb.sv
module maze_wall_union_find_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mwuf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_BEATS   = 580;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_action = ACT_WALL;
   logic [CELL_IN_W-1:0] req_cell_a = '0;
   logic [CELL_IN_W-1:0] req_cell_b = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [SLOT_W-1:0]    rsp_slot;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [GRID_W-1:0]    csr_grid_cells = GRID_RESET;

   int mismatches;
   int pending;
   int opened_seen;
   int kept_seen;
   int restart_seen;
   int range_seen;
   int idle_pct = 0;
   int stall_pct = 0;
   int beats_sent = 0;
   int restarts_sent = 0;
   int grid_writes = 0;
   int quiet_cycles = 0;

   maze_wall_union_find_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_cell_a     (req_cell_a),
      .req_cell_b     (req_cell_b),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_grid_cells (csr_grid_cells)
   );

   mwuf_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_cell_a     (req_cell_a),
      .req_cell_b     (req_cell_b),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_grid_cells (csr_grid_cells),
      .mismatches     (mismatches),
      .pending        (pending),
      .opened_seen    (opened_seen),
      .kept_seen      (kept_seen),
      .restart_seen   (restart_seen),
      .range_seen     (range_seen)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
         $display("maze_wall_union_find_unit_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic act, input int a, input int b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_cell_a <= a[CELL_IN_W-1:0];
      req_cell_b <= b[CELL_IN_W-1:0];
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (act == ACT_RESTART)
         restarts_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_grid_cells(input int cells);
      settle();
      csr_valid <= 1'b1;
      csr_grid_cells <= cells[GRID_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      grid_writes++;
   endtask

   task automatic carve_round(input int grid);
      int cells;
      int w;
      int h;
      int base;
      int j;
      int t;
      int wall_a [$];
      int wall_b [$];
      cells = (grid > 1024) ? 1024 : grid;
      write_grid_cells(grid);
      send_beat(ACT_RESTART, $urandom_range(1023), $urandom_range(1023));
      if (cells < 2) begin
         repeat (20) send_beat(ACT_WALL, $urandom_range(3), $urandom_range(3));
      end else begin
         w = $urandom_range(8, 2);
         h = $urandom_range(8, 1);
         while (w * h > cells) begin
            if (h > 1)
               h--;
            else
               w--;
         end
         base = $urandom_range(cells - w * h);
         for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
               if (x + 1 < w) begin
                  wall_a.insert(wall_a.size(), base + y * w + x);
                  wall_b.insert(wall_b.size(), base + y * w + x + 1);
               end
               if (y + 1 < h) begin
                  wall_a.insert(wall_a.size(), base + y * w + x);
                  wall_b.insert(wall_b.size(), base + (y + 1) * w + x);
               end
            end
         end
         for (int i = wall_a.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = wall_a[i];
            wall_a[i] = wall_a[j];
            wall_a[j] = t;
            t = wall_b[i];
            wall_b[i] = wall_b[j];
            wall_b[j] = t;
         end
         for (int i = 0; i < wall_a.size(); i++) begin
            if ($urandom_range(99) < 12) begin
               case ($urandom_range(9))
                  0:       send_beat(ACT_RESTART, $urandom_range(1023), $urandom_range(1023));
                  1, 2, 3: send_beat(ACT_WALL, $urandom_range(1023), $urandom_range(1023));
                  4, 5: begin
                     t = $urandom_range(cells - 1);
                     send_beat(ACT_WALL, t, t);
                  end
                  6:       send_beat(ACT_WALL, cells - 1, cells);
                  default: send_beat(ACT_WALL, $urandom_range(cells - 1),
                                     $urandom_range(cells - 1));
               endcase
            end
            if ($urandom_range(1))
               send_beat(ACT_WALL, wall_a[i], wall_b[i]);
            else
               send_beat(ACT_WALL, wall_b[i], wall_a[i]);
         end
      end
   endtask

   initial begin
      int random_start;
      int round;
      int grid;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_beat(ACT_WALL, 0, 1);
      send_beat(ACT_WALL, 1, 0);
      send_beat(ACT_WALL, 5, 5);
      send_beat(ACT_WALL, 2, 3);
      send_beat(ACT_WALL, 0, 2);
      send_beat(ACT_WALL, 3, 1);
      send_beat(ACT_WALL, 1023, 4);
      send_beat(ACT_WALL, 0, 1023);
      send_beat(ACT_WALL, 1023, 1022);
      send_beat(ACT_RESTART, 1023, 1023);
      send_beat(ACT_WALL, 0, 1023);
      write_grid_cells(16);
      send_beat(ACT_WALL, 15, 16);
      send_beat(ACT_WALL, 16, 15);
      send_beat(ACT_WALL, 15, 0);
      send_beat(ACT_WALL, 1023, 0);
      write_grid_cells(0);
      send_beat(ACT_WALL, 0, 0);
      write_grid_cells(2047);
      send_beat(ACT_WALL, 1023, 512);
      send_beat(ACT_WALL, 512, 1023);
      write_grid_cells(1);
      send_beat(ACT_WALL, 0, 0);
      send_beat(ACT_WALL, 0, 1);
      send_beat(ACT_RESTART, 0, 0);

      write_grid_cells(1024);
      send_beat(ACT_RESTART, 0, 0);

      random_start = beats_sent;
      round = 0;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         case (round % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 49;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 49;
            end
            default: begin
               idle_pct = 37;
               stall_pct = 37;
            end
         endcase
         case (round % 12)
            0:       grid = 1024;
            1:       grid = 40;
            2:       grid = 2047;
            3:       grid = 1;
            4:       grid = 100;
            5:       grid = 0;
            6:       grid = 512;
            7:       grid = 2;
            8:       grid = 64;
            9:       grid = 33;
            10:      grid = 1000;
            default: grid = $urandom_range(1024, 1);
         endcase
         carve_round(grid);
         round++;
      end

      settle();
      $display("Run covered %0d request beats (%0d restarts) with %0d grid_cells writes,",
               beats_sent, restarts_sent, grid_writes);
      $display("giving %0d opened, %0d kept, %0d restart and %0d out-of-range results.",
               opened_seen, kept_seen, restart_seen, range_seen);
      if (mismatches == 0 && pending == 0)
         $display("maze_wall_union_find_unit_tb: PASS");
      else
         $display("maze_wall_union_find_unit_tb: FAIL");
      $finish;
   end

endmodule
